@@ hdl/otq_pkg.sv @@
package otq_pkg;

    localparam int unsigned MaxTimers = 16;
    localparam int unsigned SlotW = $clog2(MaxTimers);
    localparam int unsigned CntW = $clog2(MaxTimers + 1);
    localparam int unsigned TimeW = 48;
    localparam int unsigned IdW = 16;
    localparam int unsigned IvlW = 32;
    localparam int unsigned ActW = 2;
    localparam int unsigned StatW = 2;
    localparam int unsigned QDepth = 2;

    localparam logic [ActW-1:0] ActAdd = 2'd0;
    localparam logic [ActW-1:0] ActCancel = 2'd1;
    localparam logic [ActW-1:0] ActTick = 2'd2;
    localparam logic [ActW-1:0] ActSpare = 2'd3;

    localparam logic [StatW-1:0] StOk = 2'd0;
    localparam logic [StatW-1:0] StDup = 2'd1;
    localparam logic [StatW-1:0] StFull = 2'd2;
    localparam logic [StatW-1:0] StNotFound = 2'd3;

    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

    typedef struct packed {
        logic [ActW-1:0]  action;
        logic [IdW-1:0]   tmr_id;
        logic [TimeW-1:0] expire_time;
        logic [IvlW-1:0]  repeat_interval;
        logic [TimeW-1:0] now_time;
    } t_cmd;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic             earliest_changed;
        logic             fired_valid;
        logic [IdW-1:0]   fired_id;
        logic [TimeW-1:0] fired_time;
        logic             next_valid;
        logic [TimeW-1:0] next_expire;
        logic             last;
    } t_res;

endpackage

@@ hdl/otq_fifo.sv @@
module otq_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  otq_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output otq_pkg::t_cmd o_data
);
    localparam int unsigned AW = $clog2(otq_pkg::QDepth);

    otq_pkg::t_cmd r_mem [otq_pkg::QDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(otq_pkg::QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(otq_pkg::QDepth)) else $error("count out of range");
`endif
endmodule

@@ hdl/otq_engine.sv @@
module otq_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  otq_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_res_valid,
    output otq_pkg::t_res o_res,
    input  logic          i_res_stall
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_PICK  = 6'b000100,
        S_EMIT  = 6'b001000,
        S_REARM = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    localparam int unsigned N = otq_pkg::MaxTimers;
    localparam int unsigned SW = (otq_pkg::SlotW > 0) ? otq_pkg::SlotW : 1;

    t_state r_state;
    logic [N-1:0]              r_used, r_pick;
    logic [otq_pkg::IdW-1:0]   r_id  [N];
    logic [otq_pkg::TimeW-1:0] r_exp [N];
    logic [otq_pkg::IvlW-1:0]  r_ivl [N];

    otq_pkg::t_cmd            r_cmd;
    logic [SW-1:0]            r_idx;
    logic [otq_pkg::CntW-1:0] r_nexp;
    logic [otq_pkg::CntW-1:0] r_emitted;
    logic                     r_found, r_free_ok, r_any, r_best_ok;
    logic [SW-1:0]            r_hit, r_free, r_best;
    logic [otq_pkg::TimeW-1:0] r_min;

    // result register
    logic          r_ovalid;
    otq_pkg::t_res r_ores;

    logic                      w_out_free, w_load, w_due, w_keep, w_better, w_new_min;
    logic                      w_last_slot, w_last_fire;
    logic [otq_pkg::TimeW:0]   w_sum;
    logic [otq_pkg::TimeW-1:0] w_rearm, w_after;
    otq_pkg::t_res             w_res;

    assign w_out_free  = !r_ovalid || !i_res_stall;
    assign w_load      = w_out_free && (r_state == S_DONE || r_state == S_EMIT);
    assign o_res_valid = r_ovalid;
    assign o_res       = r_ores;
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign w_last_slot = (r_idx == SW'(N - 1));
    assign w_last_fire = (r_emitted == r_nexp - otq_pkg::CntW'(1));

    // saturating re-arm of the slot under the scan pointer
    assign w_sum   = {1'b0, r_cmd.now_time} + (otq_pkg::TimeW+1)'(r_ivl[r_idx]);
    assign w_rearm = w_sum[otq_pkg::TimeW] ? otq_pkg::TimeMax : w_sum[otq_pkg::TimeW-1:0];
    assign w_due   = r_used[r_idx] && (r_exp[r_idx] <= r_cmd.now_time);
    assign w_better = !r_best_ok || r_exp[r_idx] < r_exp[r_best] ||
                      (r_exp[r_idx] == r_exp[r_best] && r_id[r_idx] < r_id[r_best]);
    assign w_new_min = !r_any || (r_cmd.expire_time < r_min);

    // slot as it stands once the item is done; every due timer fires in one tick
    // since the due count is wide enough for the whole table
    always_comb begin
        w_keep  = r_used[r_idx];
        w_after = r_exp[r_idx];
        case (r_cmd.action)
            otq_pkg::ActCancel: begin
                w_keep = r_used[r_idx] && (r_id[r_idx] != r_cmd.tmr_id);
            end
            otq_pkg::ActTick: begin
                if (w_due) begin
                    w_keep  = (r_ivl[r_idx] != '0);
                    w_after = w_rearm;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_res             = '0;
        w_res.status      = otq_pkg::StOk;
        w_res.last        = 1'b1;
        w_res.next_valid  = r_any;
        w_res.next_expire = r_any ? r_min : '0;
        if (r_state == S_EMIT) begin
            w_res.fired_valid = 1'b1;
            w_res.fired_id    = r_id[r_best];
            w_res.fired_time  = r_exp[r_best];
            w_res.last        = w_last_fire;
        end else begin
            case (r_cmd.action)
                otq_pkg::ActAdd: begin
                    if (r_found) w_res.status = otq_pkg::StDup;
                    else if (!r_free_ok) w_res.status = otq_pkg::StFull;
                    else begin
                        w_res.earliest_changed = w_new_min;
                        w_res.next_valid       = 1'b1;
                        w_res.next_expire      = w_new_min ? r_cmd.expire_time : r_min;
                    end
                end
                otq_pkg::ActCancel: begin
                    if (!r_found) w_res.status = otq_pkg::StNotFound;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
                r_ores   <= w_res;
            end else if (w_out_free) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd     <= i_cmd;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_any     <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_pick    <= '0;
                        r_nexp    <= '0;
                        r_emitted <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one slot a cycle: id lookup, free slot, due count, earliest after
                    if (r_used[r_idx] && r_id[r_idx] == r_cmd.tmr_id) begin
                        r_found <= 1'b1;
                        r_hit   <= r_idx;
                    end
                    if (!r_used[r_idx] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_idx;
                    end
                    if (w_keep && (!r_any || w_after < r_min)) begin
                        r_min <= w_after;
                        r_any <= 1'b1;
                    end
                    if (w_due) r_nexp <= r_nexp + otq_pkg::CntW'(1);
                    if (w_last_slot) begin
                        r_idx   <= '0;
                        r_state <= (r_cmd.action == otq_pkg::ActTick &&
                                    (r_nexp != '0 || w_due)) ? S_PICK : S_DONE;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_PICK: begin
                    // selection pass: earliest unpicked due slot, ties by id
                    if (w_due && !r_pick[r_idx] && w_better) begin
                        r_best_ok <= 1'b1;
                        r_best    <= r_idx;
                    end
                    if (w_last_slot) begin
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_EMIT: begin
                    // one fired beat, then pick again or re-arm
                    if (w_load) begin
                        r_pick[r_best] <= 1'b1;
                        r_best_ok      <= 1'b0;
                        r_emitted      <= r_emitted + otq_pkg::CntW'(1);
                        r_state        <= w_last_fire ? S_REARM : S_PICK;
                    end
                end
                S_REARM: begin
                    if (r_pick[r_idx]) begin
                        if (r_ivl[r_idx] != '0) r_exp[r_idx] <= w_rearm;
                        else r_used[r_idx] <= 1'b0;
                    end
                    if (w_last_slot) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_DONE: begin
                    // single beat; add and cancel apply their update here
                    if (w_load) begin
                        if (r_cmd.action == otq_pkg::ActAdd && !r_found && r_free_ok) begin
                            r_used[r_free] <= 1'b1;
                            r_id[r_free]   <= r_cmd.tmr_id;
                            r_exp[r_free]  <= r_cmd.expire_time;
                            r_ivl[r_free]  <= r_cmd.repeat_interval;
                        end
                        if (r_cmd.action == otq_pkg::ActCancel && r_found) begin
                            r_used[r_hit] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_res_stall |=> r_ovalid && $stable(r_ores))
        else $error("stalled result changed");
    a_emit_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_best_ok) else $error("emit without a pick");
`endif
endmodule

@@ hdl/ordered_timer_queue.sv @@
// an accepted beat takes the queue hop, the pop, the 16-slot scan and the result register
// on the way to its add, cancel or quiet-tick result; a tick that fires then runs a pick
// pass over the slots and an emit beat per fired timer, then a re-arm pass; the engine
// takes one item at a time while the queue holds more, and output stalls hold it up
// reset: synchronous active-low, clears the used bits, the queue and the result valid bit
module ordered_timer_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [otq_pkg::ActW-1:0]    i_action,
    input  logic [otq_pkg::IdW-1:0]     i_tmr_id,
    input  logic [otq_pkg::TimeW-1:0]   i_expire_time,
    input  logic [otq_pkg::IvlW-1:0]    i_repeat_interval,
    input  logic [otq_pkg::TimeW-1:0]   i_now_time,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [otq_pkg::StatW-1:0]   o_status,
    output logic                        o_earliest_changed,
    output logic                        o_fired_valid,
    output logic [otq_pkg::IdW-1:0]     o_fired_id,
    output logic [otq_pkg::TimeW-1:0]   o_fired_time,
    output logic                        o_next_valid,
    output logic [otq_pkg::TimeW-1:0]   o_next_expire,
    output logic                        o_last
);
    otq_pkg::t_cmd w_in, w_q;
    otq_pkg::t_res w_res;
    logic w_full, w_empty, w_pop;

    assign w_in = '{action: i_action, tmr_id: i_tmr_id, expire_time: i_expire_time,
                    repeat_interval: i_repeat_interval, now_time: i_now_time};
    assign o_stall = w_full;

    // front: command queue decouples the intake from the scanning engine
    otq_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(i_valid && !w_full), .i_data(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_data(w_q)
    );

    // back: slot table and per-slot scan sequencer
    otq_engine u_eng (
        .i_clk, .i_rst_n,
        .i_cmd_valid(!w_empty), .i_cmd(w_q), .o_cmd_pop(w_pop),
        .o_res_valid(o_valid), .o_res(w_res), .i_res_stall(i_stall)
    );

    assign o_status           = w_res.status;
    assign o_earliest_changed = w_res.earliest_changed;
    assign o_fired_valid      = w_res.fired_valid;
    assign o_fired_id         = w_res.fired_id;
    assign o_fired_time       = w_res.fired_time;
    assign o_next_valid       = w_res.next_valid;
    assign o_next_expire      = w_res.next_expire;
    assign o_last             = w_res.last;
endmodule
